FILE: rtl/topological_sort_kahn_unit_defines.svh
// Assertion macros shared by the sort unit RTL.
`ifndef TOPOLOGICAL_SORT_KAHN_UNIT_DEFINES_SVH
`define TOPOLOGICAL_SORT_KAHN_UNIT_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define TSK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define TSK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/tsk_pkg.sv
// Package with types and constants for the topological sort unit.
`default_nettype none
package tsk_pkg;
    localparam int MaxNodesDef = 64;
    localparam int MaxEdgesDef = 256;
    localparam int NodeW       = 7;
    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_POP,
        ST_POP_WAIT,
        ST_HEAD_WAIT,
        ST_EDGE_WAIT,
        ST_DEG_WAIT,
        ST_EMIT,
        ST_CHECK,
        ST_CHECK_WAIT,
        ST_FINAL,
        ST_CLEAR
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/tsk_edge_mem.sv
// Edge store memory: target and link per edge, one write and one read port.
`default_nettype none
module tsk_edge_mem
    import tsk_pkg::*;
#(
    parameter int MAX_EDGES = MaxEdgesDef,
    localparam int EW = $clog2(MAX_EDGES + 1),
    localparam int AW = $clog2(MAX_EDGES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [NodeW-1:0] i_wtarget,
    input  wire logic [EW-1:0] i_wlink,
    input  wire logic [AW-1:0] i_raddr,
    output logic [NodeW-1:0]   o_rtarget,
    output logic [EW-1:0]      o_rlink
);
    logic [NodeW+EW-1:0] mem [MAX_EDGES];
    logic [NodeW+EW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wtarget, i_wlink};
        end
        r_q <= mem[i_raddr];
    end

    assign o_rtarget = r_q[NodeW+EW-1:EW];
    assign o_rlink   = r_q[EW-1:0];
endmodule
`default_nettype wire

FILE: rtl/topological_sort_kahn_unit.sv
// Kahn topological sort unit: edge store, node table, ready stack and sequencer.
// Edge transaction: after a stored edge is accepted, the input stalls through the IDLE
// write step and DEG_WAIT. Start transaction: SCAN of the N nodes in use, POP and edge
// walk per ready node, CHECK, FINAL and CLEAR of all MAX_NODES rows; a node result
// leaves when the next node is popped, the last one after the check. Output stalls add.
// Reset (synchronous, active low): num_nodes to 64, then a node table clear.
`default_nettype none
module topological_sort_kahn_unit
    import tsk_pkg::*;
#(
    parameter int MAX_NODES = MaxNodesDef,
    parameter int MAX_EDGES = MaxEdgesDef
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [6:0]       i_cfg_num_nodes,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_kind,
    input  wire logic [NodeW-1:0] i_src_node,
    input  wire logic [NodeW-1:0] i_dst_node,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [NodeW-1:0]      o_node,
    output logic                  o_node_valid,
    output logic                  o_last,
    output logic                  o_has_cycle,
    output logic                  o_edges_dropped
);
`include "topological_sort_kahn_unit_defines.svh"
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int AW = $clog2(MAX_EDGES);
    localparam int NA = $clog2(MAX_NODES);
    localparam int SW = $clog2(MAX_NODES + 1);
    localparam int DW = EW;
    localparam logic [EW-1:0] NULL_E = EW'(MAX_EDGES);
    localparam logic [NodeW-1:0] MAXN = NodeW'(MAX_NODES);

    // node table: degree and list head, written at one address, read at one
    logic [DW+EW-1:0] node_mem [MAX_NODES];
    logic [DW+EW-1:0] r_nq;
    logic [NodeW-1:0] stack_mem [MAX_NODES];
    logic [NodeW-1:0] r_sq;

    t_state r_state, n_state;
    logic [6:0]       r_num;
    logic [EW-1:0]    r_total, n_total;
    logic             r_ovf, n_ovf;
    logic [SW-1:0]    r_sp, n_sp;
    logic [NodeW-1:0] r_idx, n_idx;
    logic [NodeW-1:0] r_id, n_id;
    logic [NodeW-1:0] r_hold, n_hold;
    logic [EW-1:0]    r_e, n_e;
    logic [EW:0]      r_steps, n_steps;
    logic [NodeW:0]   r_cnt, n_cnt;
    logic             r_cyc, n_cyc;
    logic [NodeW-1:0] r_tgt, n_tgt;
    logic             r_ov, n_ov;
    logic [NodeW-1:0] r_onode, n_onode;
    logic             r_onv, n_onv, r_olast, n_olast, r_ocyc, n_ocyc, r_odrop, n_odrop;

    logic             nm_we;
    logic [NA-1:0]    nm_wa, nm_ra;
    logic [DW+EW-1:0] nm_wd;
    logic             st_we;
    logic [NA-1:0]    st_wa, st_ra;
    logic [NodeW-1:0] st_wd;
    logic             em_we;
    logic [AW-1:0]    em_ra;
    logic [NodeW-1:0] em_tgt;
    logic [EW-1:0]    em_lnk;
    logic [NodeW-1:0] n_eff;
    logic             acc, edge_ok;
    logic [DW-1:0]    deg;
    logic [EW-1:0]    head;
    logic [NodeW-1:0] s_m1, d_m1;

    always_ff @(posedge i_clk) begin
        if (nm_we) begin
            node_mem[nm_wa] <= nm_wd;
        end
        r_nq <= node_mem[nm_ra];
        if (st_we) begin
            stack_mem[st_wa] <= st_wd;
        end
        r_sq <= stack_mem[st_ra];
    end

    // the edge is written while the source row sits on the read port
    tsk_edge_mem #(.MAX_EDGES(MAX_EDGES)) u_edge (
        .i_clk    (i_clk),
        .i_we     (em_we),
        .i_waddr  (r_total[AW-1:0]),
        .i_wtarget(r_tgt),
        .i_wlink  (head),
        .i_raddr  (em_ra),
        .o_rtarget(em_tgt),
        .o_rlink  (em_lnk)
    );

    assign n_eff  = (r_num > MAXN) ? MAXN : r_num;
    assign deg    = r_nq[DW+EW-1:EW];
    assign head   = r_nq[EW-1:0];
    assign s_m1   = i_src_node - NodeW'(1);
    assign d_m1   = i_dst_node - NodeW'(1);
    assign acc    = i_valid && !o_stall;
    assign edge_ok = (i_src_node != '0) && (i_src_node <= n_eff) &&
                     (i_dst_node != '0) && (i_dst_node <= n_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_num   <= 7'd64;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_sp    <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_cyc   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_num <= i_cfg_num_nodes;
            end
            r_total <= n_total;
            r_ovf   <= n_ovf;
            r_sp    <= n_sp;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_cyc   <= n_cyc;
            r_ov    <= n_ov;
        end
        r_id    <= n_id;
        r_hold  <= n_hold;
        r_e     <= n_e;
        r_steps <= n_steps;
        r_tgt   <= n_tgt;
        r_onode <= n_onode;
        r_onv   <= n_onv;
        r_olast <= n_olast;
        r_ocyc  <= n_ocyc;
        r_odrop <= n_odrop;
    end

    // Edge load is a read-modify-write of the source row in IDLE, then of the
    // destination row in DEG_WAIT; the input stalls while the node table is updated.
    logic             r_ephase;
    logic [NA-1:0]    r_es, r_ed;
    logic             n_ephase;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ephase <= 1'b0;
        end else begin
            r_ephase <= n_ephase;
        end
        if (acc) begin
            r_es <= s_m1[NA-1:0];
            r_ed <= d_m1[NA-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_total = r_total;
        n_ovf   = r_ovf;
        n_sp    = r_sp;
        n_idx   = r_idx;
        n_id    = r_id;
        n_hold  = r_hold;
        n_e     = r_e;
        n_steps = r_steps;
        n_cnt   = r_cnt;
        n_cyc   = r_cyc;
        n_tgt   = r_tgt;
        n_ov    = r_ov;
        n_ephase = r_ephase;
        n_onode = r_onode;
        n_onv   = r_onv;
        n_olast = r_olast;
        n_ocyc  = r_ocyc;
        n_odrop = r_odrop;
        nm_we   = 1'b0;
        nm_wa   = '0;
        nm_wd   = '0;
        nm_ra   = '0;
        st_we   = 1'b0;
        st_wa   = r_sp[NA-1:0];
        st_wd   = '0;
        st_ra   = '0;
        em_we   = 1'b0;
        em_ra   = r_e[AW-1:0];
        o_stall = 1'b1;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (r_ephase) begin
                    // first half done: read source row is in r_nq; next step dst
                    o_stall = 1'b1;
                    n_tgt = r_tgt;
                    nm_we = 1'b1;
                    nm_wa = r_es;
                    nm_wd = {deg, r_total};
                    em_we = 1'b1;
                    n_total = r_total + EW'(1);
                    nm_ra = r_ed;
                    n_state = ST_DEG_WAIT;
                    n_ephase = 1'b0;
                end else begin
                    o_stall = 1'b0;
                    nm_ra = s_m1[NA-1:0];
                    if (acc) begin
                        if (i_kind == KIND_START) begin
                            n_sp  = '0;
                            n_idx = '0;
                            n_cnt = '0;
                            n_cyc = 1'b0;
                            n_state = (n_eff == '0) ? ST_POP : ST_SCAN;
                        end else if (edge_ok) begin
                            if (r_total >= EW'(MAX_EDGES)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_tgt = i_dst_node;
                                n_ephase = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_DEG_WAIT: begin
                // degree increment of the edge destination, then back to idle
                // a self edge read its row before the new head landed; forward it
                nm_we = 1'b1;
                nm_wa = r_ed;
                nm_wd = {deg + DW'(1), head};
                if (r_ed == r_es) begin
                    nm_wd = {deg + DW'(1), r_total - EW'(1)};
                end
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                nm_ra = r_idx[NA-1:0];
                n_state = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT: begin
                if (deg == '0) begin
                    st_we = 1'b1;
                    st_wa = r_sp[NA-1:0];
                    st_wd = r_idx + NodeW'(1);
                    n_sp  = r_sp + SW'(1);
                end
                n_idx = r_idx + NodeW'(1);
                n_state = (r_idx + NodeW'(1) >= n_eff) ? ST_POP : ST_SCAN;
            end
            ST_POP: begin
                if (r_sp == '0 || r_cnt >= (NodeW+1)'(MAX_NODES)) begin
                    n_idx = '0;
                    n_state = (n_eff == '0) ? ST_FINAL : ST_CHECK;
                end else begin
                    st_ra = r_sp[NA-1:0] - NA'(1);
                    n_sp  = r_sp - SW'(1);
                    n_state = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: begin
                n_id = r_sq;
                nm_ra = r_sq[NA-1:0] - NA'(1);
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // hold the node row on the read port while the output waits
                nm_ra = r_id[NA-1:0] - NA'(1);
                if (r_cnt == '0 || !r_ov || !i_stall) begin
                    // send the previous node; the newest one waits for the next node or the final flags
                    if (r_cnt != '0) begin
                        n_ov = 1'b1;
                        n_onode = r_hold;
                        n_onv = 1'b1;
                        n_olast = 1'b0;
                        n_ocyc = 1'b0;
                        n_odrop = 1'b0;
                    end
                    n_hold = r_id;
                    n_cnt = r_cnt + (NodeW+1)'(1);
                    n_e = head;
                    n_steps = '0;
                    n_state = ST_HEAD_WAIT;
                end
            end
            ST_HEAD_WAIT: begin
                if (r_e < r_total && r_steps < (EW+1)'(MAX_EDGES)) begin
                    em_ra = r_e[AW-1:0];
                    n_state = ST_EDGE_WAIT;
                end else begin
                    n_state = ST_POP;
                end
            end
            ST_EDGE_WAIT: begin
                n_tgt = em_tgt;
                n_e = em_lnk;
                n_steps = r_steps + (EW+1)'(1);
                nm_ra = em_tgt[NA-1:0] - NA'(1);
                n_state = ST_CHECK_WAIT;
            end
            ST_CHECK_WAIT: begin
                if (deg != '0) begin
                    nm_we = 1'b1;
                    nm_wa = r_tgt[NA-1:0] - NA'(1);
                    nm_wd = {deg - DW'(1), head};
                    if (deg == DW'(1)) begin
                        st_we = 1'b1;
                        st_wa = r_sp[NA-1:0];
                        st_wd = r_tgt;
                        n_sp = r_sp + SW'(1);
                    end
                end
                n_state = ST_HEAD_WAIT;
            end
            ST_CHECK: begin
                nm_ra = r_idx[NA-1:0];
                n_state = ST_FINAL;
                if (r_idx < n_eff) begin
                    n_idx = r_idx + NodeW'(1);
                    n_state = ST_CHECK;
                end
                if (r_idx != '0 && deg != '0 && r_idx <= n_eff) begin
                    n_cyc = 1'b1;
                end
            end
            ST_FINAL: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_onode = (r_cnt == '0) ? '0 : r_hold;
                    n_onv = (r_cnt != '0);
                    n_olast = 1'b1;
                    n_ocyc = r_cyc;
                    n_odrop = r_ovf;
                    n_idx = '0;
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                nm_we = 1'b1;
                nm_wa = r_idx[NA-1:0];
                nm_wd = {DW'(0), NULL_E};
                n_idx = r_idx + NodeW'(1);
                n_total = '0;
                n_ovf = 1'b0;
                n_sp = '0;
                if (r_idx + NodeW'(1) >= MAXN) begin
                    n_idx = '0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid         = r_ov;
    assign o_node          = r_onode;
    assign o_node_valid    = r_onv;
    assign o_last          = r_olast;
    assign o_has_cycle     = r_ocyc;
    assign o_edges_dropped = r_odrop;

    `TSK_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != ST_IDLE, o_stall, "accept while busy")
    `TSK_ASSERT_IMP(a_flags_last, i_clk, i_rst_n, o_valid && !o_last, !o_has_cycle && !o_edges_dropped, "flags off last")
    `TSK_ASSERT_NXT(a_final_clear, i_clk, i_rst_n, r_state == ST_FINAL && !(r_ov && i_stall), r_state == ST_CLEAR, "final not followed by clear")
endmodule
`default_nettype wire

FILE: sim/tb_topological_sort_kahn_unit.sv
// Self-checking testbench for the Kahn topological sort unit.
module tb_topological_sort_kahn_unit
    import tsk_pkg::*;
();

    localparam int NODES = 64;
    localparam int EDGES = 256;
    localparam int WATCHDOG = 6000;

    typedef struct packed {
        logic       kind;
        logic [6:0] src;
        logic [6:0] dst;
    } t_graph_item;

    typedef struct packed {
        logic [6:0] node;
        logic       node_valid;
        logic       last;
        logic       has_cycle;
        logic       edges_dropped;
    } t_order;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [6:0] i_cfg_num_nodes = 7'd0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_kind = 1'b0;
    logic [6:0] i_src_node = 7'd0;
    logic [6:0] i_dst_node = 7'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [6:0] o_node;
    logic       o_node_valid;
    logic       o_last;
    logic       o_has_cycle;
    logic       o_edges_dropped;

    topological_sort_kahn_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_num_nodes (i_cfg_num_nodes),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_src_node      (i_src_node),
        .i_dst_node      (i_dst_node),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_node          (o_node),
        .o_node_valid    (o_node_valid),
        .o_last          (o_last),
        .o_has_cycle     (o_has_cycle),
        .o_edges_dropped (o_edges_dropped)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the graph store
    int node_count = 64;
    int in_deg[NODES];
    int head[NODES];
    int edge_dst[EDGES];
    int edge_next[EDGES];
    int edge_cnt;
    bit overflow;

    t_graph_item pending_items[$];
    t_order      expected_order[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 1'b0;
    bit  long_hold = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;

    function automatic void clear_graph();
        for (int i = 0; i < NODES; i++) begin
            in_deg[i] = 0;
            head[i] = EDGES;
        end
        edge_cnt = 0;
        overflow = 1'b0;
    endfunction

    function automatic void load_edge(int s, int d);
        int n;
        n = node_count > NODES ? NODES : node_count;
        if (s == 0 || s > n || d == 0 || d > n) return;
        if (edge_cnt >= EDGES) begin
            overflow = 1'b1;
            return;
        end
        edge_dst[edge_cnt] = d;
        edge_next[edge_cnt] = head[s-1];
        head[s-1] = edge_cnt;
        edge_cnt++;
        in_deg[d-1]++;
    endfunction

    function automatic void sort_graph();
        int n, depth, emitted, id, e, t;
        int ready[NODES];
        bit cyc;
        t_order r;
        n = node_count > NODES ? NODES : node_count;
        depth = 0;
        emitted = 0;
        cyc = 1'b0;
        for (int i = 1; i <= n; i++)
            if (in_deg[i-1] == 0) begin
                ready[depth] = i;
                depth++;
            end
        while (depth > 0 && emitted < NODES) begin
            depth--;
            id = ready[depth];
            r = '0;
            r.node = id[6:0];
            r.node_valid = 1'b1;
            expected_order.push_back(r);
            emitted++;
            e = head[id-1];
            while (e < edge_cnt) begin
                t = edge_dst[e];
                if (in_deg[t-1] != 0) begin
                    in_deg[t-1]--;
                    if (in_deg[t-1] == 0 && depth < NODES) begin
                        ready[depth] = t;
                        depth++;
                    end
                end
                e = edge_next[e];
            end
        end
        for (int i = 1; i <= n; i++)
            if (in_deg[i-1] != 0) cyc = 1'b1;
        if (emitted == 0) expected_order.push_back('0);
        r = expected_order.pop_back();
        r.last = 1'b1;
        r.has_cycle = cyc;
        r.edges_dropped = overflow;
        expected_order.push_back(r);
        clear_graph();
    endfunction

    function automatic int pick_gap();
        int p;
        if (no_gaps) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // driver: offer pending transactions, predict on acceptance
    always @(posedge i_clk) begin
        t_graph_item it;
        logic busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid;
            if (i_valid && !o_stall) begin
                busy = 1'b0;
                if (i_kind == KIND_START) sort_graph();
                else load_edge(i_src_node, i_dst_node);
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= it.kind;
                    i_src_node <= it.src;
                    i_dst_node <= it.dst;
                    gap_left <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check results and drive the output stall
    always @(posedge i_clk) begin
        t_order want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_order.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result node=%0d last=%0b", o_node, o_last);
            end else begin
                want = expected_order.pop_front();
                if (o_node !== want.node || o_node_valid !== want.node_valid ||
                    o_last !== want.last || o_has_cycle !== want.has_cycle ||
                    o_edges_dropped !== want.edges_dropped) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d %0b %0b %0b %0b got %0d %0b %0b %0b %0b",
                                 want.node, want.node_valid, want.last, want.has_cycle,
                                 want.edges_dropped, o_node, o_node_valid, o_last,
                                 o_has_cycle, o_edges_dropped);
                end
            end
        end
        if (long_hold) begin
            stall_left <= 400;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!no_gaps && $urandom_range(0, 99) < 30) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog: count cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("topological_sort_kahn_unit regression: fail");
            $finish;
        end
    end

    task automatic add_item(logic kind, int s, int d);
        t_graph_item it;
        it.kind = kind;
        it.src = s[6:0];
        it.dst = d[6:0];
        pending_items.push_back(it);
    endtask

    // hold the sender until the unit is drained, then let the clear pass finish
    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_order.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_nodes(int n);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_num_nodes <= n[6:0];
        node_count = n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random graph on 1..n: mostly acyclic, sometimes a back edge or noise
    task automatic add_graph(int n, ref int sent);
        int k, a, b;
        k = $urandom_range(0, 3 * n);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                add_item(KIND_EDGE, $urandom_range(0, 127), $urandom_range(0, 127));
            end else begin
                a = $urandom_range(1, n);
                b = $urandom_range(1, n);
                if (a > b && $urandom_range(0, 19) != 0) add_item(KIND_EDGE, b, a);
                else if (a != b) add_item(KIND_EDGE, a, b);
                else add_item(KIND_EDGE, a, ($urandom_range(0, 3) == 0) ? 0 : n + 1);
            end
            sent++;
        end
        add_item(KIND_START, $urandom_range(0, 127), $urandom_range(0, 127));
        sent++;
    endtask

    initial begin
        int sent, n;
        bit held;
        clear_graph();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (150) @(posedge i_clk);

        // empty graph at full size, then boundary ids, invalid ids and a cycle
        add_item(KIND_START, 0, 0);
        add_item(KIND_EDGE, 64, 1);
        add_item(KIND_EDGE, 1, 64);
        add_item(KIND_EDGE, 0, 5);
        add_item(KIND_EDGE, 65, 3);
        add_item(KIND_EDGE, 127, 127);
        add_item(KIND_EDGE, 5, 0);
        add_item(KIND_EDGE, 2, 3);
        add_item(KIND_EDGE, 3, 2);
        add_item(KIND_START, 127, 127);
        drain();
        set_nodes(1);
        add_item(KIND_EDGE, 1, 1);
        add_item(KIND_START, 0, 0);
        drain();
        // shrink the node range after loading: node 3 still comes out
        set_nodes(3);
        add_item(KIND_EDGE, 1, 2);
        add_item(KIND_EDGE, 2, 3);
        add_item(KIND_EDGE, 1, 3);
        drain();
        set_nodes(2);
        add_item(KIND_START, 0, 0);
        drain();
        set_nodes(0);
        add_item(KIND_EDGE, 1, 1);
        add_item(KIND_START, 0, 0);
        drain();
        set_nodes(127);
        add_item(KIND_EDGE, 64, 63);
        add_item(KIND_START, 0, 0);
        drain();

        // fill the edge store past capacity
        set_nodes(4);
        for (int i = 0; i < 262; i++) begin
            n = $urandom_range(1, 3);
            add_item(KIND_EDGE, n, $urandom_range(n + 1, 4));
        end
        add_item(KIND_START, 0, 0);
        drain();

        sent = 0;
        held = 1'b0;
        while (sent < 60) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            n = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(2, 12);
            if (!held) n = 6;
            set_nodes(n);
            add_graph(n, sent);
            if ($urandom_range(0, 1)) add_graph(n, sent);
            if (!held) begin
                // block the output while the sender keeps offering
                add_graph(n, sent);
                add_graph(n, sent);
                @(posedge i_clk);
                long_hold <= 1'b1;
                @(posedge i_clk);
                long_hold <= 1'b0;
                held = 1'b1;
            end
            drain();
        end
        no_gaps = 1'b0;
        set_nodes(64);
        add_graph(64, sent);
        drain();

        if (errors == 0 && expected_order.size() == 0)
            $display("topological_sort_kahn_unit regression: pass");
        else
            $display("topological_sort_kahn_unit regression: fail");
        $finish;
    end
endmodule
